/* sv/assert_macros.svh */
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FCA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define FCA_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also covers the reset cycle.
`define FCA_ASSERT_NXT_ALL(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/fca_pkg.sv */
// Types, codes and the divider step for the FAT cluster address unit.
// No dependencies.
`default_nettype none
package fca_pkg;

  localparam logic [1:0] KIND_FAT12 = 2'd0;
  localparam logic [1:0] KIND_FAT16 = 2'd1;
  localparam logic [1:0] KIND_FAT32 = 2'd2;
  localparam logic [1:0] KIND_BAD   = 2'd3;

  localparam logic [2:0] REG_BYTES_PER_SECTOR    = 3'd0;
  localparam logic [2:0] REG_SECTORS_PER_CLUSTER = 3'd1;
  localparam logic [2:0] REG_RESERVED_SECTORS    = 3'd2;
  localparam logic [2:0] REG_FAT_COUNT           = 3'd3;
  localparam logic [2:0] REG_ROOT_ENTRIES        = 3'd4;
  localparam logic [2:0] REG_TOTAL_SMALL         = 3'd5;
  localparam logic [2:0] REG_TOTAL_LARGE         = 3'd6;
  localparam logic [2:0] REG_SECTORS_PER_FAT     = 3'd7;

  localparam int FAT_OFF_W  = 30;
  localparam int DIV_BITS   = 3;
  localparam int DIV_STAGES = FAT_OFF_W / DIV_BITS;

  localparam logic [31:0] FAT12_LIMIT = 32'd4085;
  localparam logic [31:0] FAT16_LIMIT = 32'd65525;
  localparam logic [27:0] EOC_FAT12   = 28'h0000FF8;
  localparam logic [27:0] EOC_FAT16   = 28'h000FFF8;
  localparam logic [27:0] EOC_FAT32   = 28'hFFFFFF8;
  localparam logic [15:0] MASK_FAT12  = 16'h0FFF;

  typedef struct packed {
    logic        mode;
    logic [27:0] cluster;
    logic [31:0] fat_word;
  } item_t;

  typedef struct packed {
    logic [1:0]  volume_kind;
    logic [31:0] data_sector;
    logic [31:0] table_sector;
    logic [11:0] entry_offset;
    logic [27:0] next_cluster;
    logic        end_of_chain;
  } result_t;

  typedef struct packed {
    logic [12:0]          rem;
    logic [FAT_OFF_W-1:0] dq;
  } div_t;

  typedef struct packed {
    logic        mode;
    logic [1:0]  kind;
    div_t        div;
    logic [31:0] prod;
    logic [27:0] next;
    logic        eoc;
  } pipe_t;

  // One restoring step: shift in the top dividend bit, subtract if it fits.
  function automatic div_t div_step(input div_t s, input logic [12:0] d);
    logic [13:0] sh;
    div_t o;
    sh = {s.rem, s.dq[FAT_OFF_W-1]};
    if (sh >= {1'b0, d}) begin
      o.rem = 13'(sh - {1'b0, d});
      o.dq  = {s.dq[FAT_OFF_W-2:0], 1'b1};
    end else begin
      o.rem = sh[12:0];
      o.dq  = {s.dq[FAT_OFF_W-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage
`default_nettype wire

/* sv/fat_cluster_address_unit.sv */
// FAT cluster address unit: volume geometry, cluster locate and FAT decode.
// Depends on fca_pkg.
`default_nettype none
// Usage: write the boot-sector fields through wr_en/wr_index/wr_data. After
// reset and after every register write the unit re-derives the volume type
// and first data sector; busy stays high while it does (a shift-subtract
// division for root sectors, a multiply and an add, then a shift-subtract
// division for cluster count). While busy is low one word may be issued
// every cycle with start. Each word gives one result word, shown for
// exactly one cycle with valid: the capture register loads on the edge
// that took it, then ten stages of the entry-offset divider (three quotient
// bits per stage over the 30-bit FAT byte offset) and the output register
// follow.
// The receiver cannot hold results off; nothing here stalls.
module fat_cluster_address_unit
  import fca_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire item_t       item,
  input  wire logic        wr_en,
  input  wire logic [2:0]  wr_index,
  input  wire logic [31:0] wr_data,
  output logic             valid,
  output result_t          result
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_START = 3'd1;
  localparam logic [2:0] ST_ROOT  = 3'd2;
  localparam logic [2:0] ST_MUL   = 3'd3;
  localparam logic [2:0] ST_SUM   = 3'd4;
  localparam logic [2:0] ST_DATA  = 3'd5;
  localparam logic [2:0] ST_CLU   = 3'd6;

  // boot-sector registers
  logic [12:0] bytes_per_sector;
  logic [7:0]  sectors_per_cluster;
  logic [15:0] reserved_sectors;
  logic [7:0]  num_fats;
  logic [15:0] root_entries;
  logic [15:0] total_sectors_small;
  logic [31:0] total_sectors_large;
  logic [31:0] sectors_per_fat;

  // derived state
  logic [31:0] first_data_start;
  logic [1:0]  kind_cache;

  // geometry sequencer
  logic [2:0]  state;
  logic [4:0]  cnt;
  logic [12:0] drem;
  logic [31:0] ddq;
  logic [31:0] root_secs;
  logic [39:0] fat_secs;
  logic [40:0] meta;

  logic [12:0] ddiv;
  logic [13:0] dsh;
  logic        dge;
  logic [12:0] drem_next;
  logic [31:0] ddq_next;
  logic [31:0] total;

  assign busy  = (state != ST_IDLE);
  assign total = (total_sectors_small != 16'd0) ? {16'd0, total_sectors_small}
                                                : total_sectors_large;

  // one bit per cycle, shared by both geometry divisions
  always_comb begin
    ddiv      = (state == ST_ROOT) ? bytes_per_sector : {5'd0, sectors_per_cluster};
    dsh       = {drem, ddq[31]};
    dge       = (dsh >= {1'b0, ddiv});
    drem_next = dge ? 13'(dsh - {1'b0, ddiv}) : dsh[12:0];
    ddq_next  = {ddq[30:0], dge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_per_sector    <= 13'd512;
      sectors_per_cluster <= 8'd1;
      reserved_sectors    <= 16'd1;
      num_fats            <= 8'd2;
      root_entries        <= 16'd512;
      total_sectors_small <= 16'd0;
      total_sectors_large <= 32'd0;
      sectors_per_fat     <= 32'd0;
      first_data_start    <= 32'd0;
      kind_cache          <= KIND_FAT12;
      state               <= ST_START;
      cnt                 <= 5'd0;
    end else if (wr_en) begin
      case (wr_index)
        REG_BYTES_PER_SECTOR:    bytes_per_sector    <= wr_data[12:0];
        REG_SECTORS_PER_CLUSTER: sectors_per_cluster <= wr_data[7:0];
        REG_RESERVED_SECTORS:    reserved_sectors    <= wr_data[15:0];
        REG_FAT_COUNT:           num_fats            <= wr_data[7:0];
        REG_ROOT_ENTRIES:        root_entries        <= wr_data[15:0];
        REG_TOTAL_SMALL:         total_sectors_small <= wr_data[15:0];
        REG_TOTAL_LARGE:         total_sectors_large <= wr_data;
        REG_SECTORS_PER_FAT:     sectors_per_fat     <= wr_data;
        default: ;
      endcase
      state <= ST_START;
    end else begin
      case (state)
        ST_START: begin
          drem <= 13'd0;
          cnt  <= 5'd0;
          if (bytes_per_sector != 13'd0) begin
            // ceil(entries*32 / bps)
            ddq   <= {11'd0, root_entries, 5'd0} + {19'd0, bytes_per_sector} - 32'd1;
            state <= ST_ROOT;
          end else begin
            root_secs <= 32'd0;
            state     <= ST_MUL;
          end
        end
        ST_ROOT: begin
          drem <= drem_next;
          ddq  <= ddq_next;
          cnt  <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            root_secs <= ddq_next;
            state     <= ST_MUL;
          end
        end
        ST_MUL: begin
          fat_secs <= 40'(num_fats) * 40'(sectors_per_fat);
          state    <= ST_SUM;
        end
        ST_SUM: begin
          meta  <= 41'(reserved_sectors) + 41'(fat_secs) + 41'(root_secs);
          state <= ST_DATA;
        end
        ST_DATA: begin
          first_data_start <= meta[31:0];
          // data area saturates at zero
          ddq  <= ({9'd0, total} > meta) ? 32'(41'(total) - meta) : 32'd0;
          drem <= 13'd0;
          cnt  <= 5'd0;
          if (sectors_per_cluster == 8'd0) begin
            kind_cache <= KIND_BAD;
            state      <= ST_IDLE;
          end else begin
            state <= ST_CLU;
          end
        end
        ST_CLU: begin
          drem <= drem_next;
          ddq  <= ddq_next;
          cnt  <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            if (ddq_next < FAT12_LIMIT)      kind_cache <= KIND_FAT12;
            else if (ddq_next < FAT16_LIMIT) kind_cache <= KIND_FAT16;
            else                             kind_cache <= KIND_FAT32;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // ---------------- item pipeline ----------------
  logic [DIV_STAGES:0] pv;
  pipe_t               pipe [0:DIV_STAGES];
  pipe_t               pipe_nx [1:DIV_STAGES];
  pipe_t               cap;

  logic [FAT_OFF_W-1:0] fat_off;
  logic [31:0]          cl_m2;
  logic [39:0]          prod_full;
  logic [15:0]          low16;

  // capture stage: FAT byte offset, cluster-to-sector product, decode
  always_comb begin
    case (kind_cache)
      KIND_FAT12: fat_off = 30'((31'(item.cluster) * 31'd3) >> 1);
      KIND_FAT16: fat_off = {1'b0, item.cluster, 1'b0};
      default:    fat_off = {item.cluster, 2'b00};
    endcase
    cl_m2     = {4'd0, item.cluster} - 32'd2;
    prod_full = 40'(cl_m2) * 40'(sectors_per_cluster);
    low16     = item.fat_word[15:0];

    cap.mode    = item.mode;
    cap.kind    = kind_cache;
    cap.div.rem = 13'd0;
    cap.div.dq  = fat_off;
    cap.prod    = prod_full[31:0];
    cap.next    = 28'd0;
    cap.eoc     = 1'b0;
    if (item.mode) begin
      case (kind_cache)
        KIND_FAT12: begin
          cap.next = item.cluster[0] ? {16'd0, low16[15:4]} : {12'd0, low16 & MASK_FAT12};
          cap.eoc  = (cap.next >= EOC_FAT12);
        end
        KIND_FAT16: begin
          cap.next = {12'd0, low16};
          cap.eoc  = (cap.next >= EOC_FAT16);
        end
        KIND_FAT32: begin
          cap.next = item.fat_word[27:0];
          cap.eoc  = (cap.next >= EOC_FAT32);
        end
        default: begin
          cap.next = 28'd0;
          cap.eoc  = 1'b1;
        end
      endcase
    end
  end

  // each stage retires DIV_BITS quotient bits
  always_comb begin
    for (int k = 1; k <= DIV_STAGES; k++) begin
      pipe_nx[k] = pipe[k-1];
      for (int j = 0; j < DIV_BITS; j++) begin
        pipe_nx[k].div = div_step(pipe_nx[k].div, bytes_per_sector);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= '0;
    end else begin
      pv <= {pv[DIV_STAGES-1:0], start & ~busy};
    end
  end

  always_ff @(posedge clk) begin
    pipe[0] <= cap;
    for (int k = 1; k <= DIV_STAGES; k++) begin
      pipe[k] <= pipe_nx[k];
    end
  end

  // output register
  pipe_t fin;
  assign fin = pipe[DIV_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= pv[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    result.volume_kind  <= fin.kind;
    result.next_cluster <= fin.next;
    result.end_of_chain <= fin.eoc;
    if (fin.mode) begin
      result.data_sector  <= 32'd0;
      result.table_sector <= 32'd0;
      result.entry_offset <= 12'd0;
    end else begin
      result.data_sector <= first_data_start + fin.prod;
      if (fin.kind != KIND_BAD && bytes_per_sector != 13'd0) begin
        result.table_sector <= {16'd0, reserved_sectors} + 32'(fin.div.dq);
        result.entry_offset <= fin.div.rem[11:0];
      end else begin
        result.table_sector <= {16'd0, reserved_sectors};
        result.entry_offset <= 12'd0;
      end
    end
  end

endmodule
`default_nettype wire

/* sv/fca_checker.sv */
// Port-level checks for the FAT cluster address unit, bound to the top level.
// Depends on fca_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module fca_port_checks
  import fca_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire item_t       item,
  input wire logic        wr_en,
  input wire logic [2:0]  wr_index,
  input wire logic [31:0] wr_data,
  input wire logic        valid,
  input wire result_t     result
);

  // geometry is re-derived after reset and after any write
  `FCA_ASSERT_NXT_ALL(a_busy_after_rst, clk, rst, busy, "not busy after reset")
  `FCA_ASSERT_NXT(a_busy_after_wr, clk, rst, wr_en, busy, "not busy after write")
  // locate fields and decode fields never both carry data
  `FCA_ASSERT_IMP(a_mode_fields, clk, rst, valid,
    (result.next_cluster == 28'd0 && !result.end_of_chain) ||
    (result.data_sector == 32'd0 && result.table_sector == 32'd0 &&
     result.entry_offset == 12'd0), "locate and decode fields mixed")
  // invalid volume has no entry offset
  `FCA_ASSERT_IMP(a_bad_offset, clk, rst, valid && result.volume_kind == KIND_BAD,
    result.entry_offset == 12'd0, "offset on invalid volume")

endmodule

bind fat_cluster_address_unit fca_port_checks u_fca_checker (.*);
`default_nettype wire
